### hdl/bts_pkg.sv
// Shared types and constants for the beep tone sequencer.
// No dependencies; every other file but bts_ifs imports this package.
package bts_pkg;

    typedef enum logic [1:0] {
        MODE_SLEEP  = 2'd0,
        MODE_RESUME = 2'd1,
        MODE_TONE   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ACT_ENQUEUE    = 2'd0,
        ACT_BACKGROUND = 2'd1,
        ACT_WAKEUP     = 2'd2
    } act_t;

    localparam logic CFG_PITCH_OFFSET = 1'b0;
    localparam logic CFG_LENGTH_SCALE = 1'b1;

    localparam logic [10:0] DAC_MULT = 11'd1525;

    // One tone fragment as held in the ring and in the player.
    typedef struct packed {
        logic [9:0] freq;
        logic [7:0] dur;
        logic [7:0] pause;
        logic [3:0] rep;
        logic [7:0] step;
    } frag_t;

    // Input word after fragment preparation.
    typedef struct packed {
        act_t       action;
        logic       urgent;
        frag_t      frag;
        logic [8:0] bg_freq;
        logic [7:0] bg_len;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic        wake_request;
        logic        tone_on;
        logic        freq_valid;
        logic [20:0] tone_frequency;
        logic        timer_start;
        logic [8:0]  timer_ticks;
        mode_t       player_state;
    } res_t;

endpackage

### hdl/bts_ifs.sv
// Handshake channels of the beep tone sequencer: input words, result words
// and configuration writes. No dependencies.
interface bts_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [7:0]        tone_freq;
    logic [7:0]        tone_len;
    logic [7:0]        tone_pause;
    logic [3:0]        repeat_count;
    logic              urgent;
    logic signed [7:0] freq_step;

    modport source (output valid, action, tone_freq, tone_len, tone_pause,
                    repeat_count, urgent, freq_step, input ready);
    modport sink (input valid, action, tone_freq, tone_len, tone_pause,
                  repeat_count, urgent, freq_step, output ready);
endinterface

interface bts_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        wake_request;
    logic        tone_on;
    logic        freq_valid;
    logic [20:0] tone_frequency;
    logic        timer_start;
    logic [8:0]  timer_ticks;
    logic [1:0]  player_state;

    modport source (output valid, accepted, wake_request, tone_on, freq_valid,
                    tone_frequency, timer_start, timer_ticks, player_state,
                    input ready);
    modport sink (input valid, accepted, wake_request, tone_on, freq_valid,
                  tone_frequency, timer_start, timer_ticks, player_state,
                  output ready);
endinterface

interface bts_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/bts_frag_prep.sv
// Fragment preparation: pitch offset and length scaling of an enqueue word.
// Depends on bts_pkg.
module bts_frag_prep
    import bts_pkg::*;
(
    input  logic [7:0] tone_freq,
    input  logic [7:0] tone_len,
    input  logic [7:0] tone_pause,
    input  logic [3:0] repeat_count,
    input  logic [7:0] freq_step,
    input  logic [7:0] pitch_offset,
    input  logic [2:0] length_scale,
    output frag_t      frag
);
    // Reciprocals exact for all 8-bit dividends.
    localparam logic [7:0] RECIP3 = 8'd171;
    localparam logic [7:0] RECIP5 = 8'd205;

    logic [7:0]  freq_adj;
    logic [7:0]  len_scaled;
    logic [15:0] prod3;
    logic [15:0] prod5;

    assign freq_adj = (tone_freq != 8'd0) ? tone_freq + pitch_offset : 8'd0;
    assign prod3 = {8'd0, tone_len} * {8'd0, RECIP3};
    assign prod5 = {8'd0, tone_len} * {8'd0, RECIP5};

    always_comb
    begin
        case (length_scale)
            3'b000:  len_scaled = tone_len;
            3'b001:  len_scaled = {tone_len[6:0], 1'b0};
            3'b010:  len_scaled = tone_len + {tone_len[6:0], 1'b0};
            3'b011:  len_scaled = {tone_len[5:0], 2'b00};
            3'b100:  len_scaled = {2'b00, prod5[15:10]};
            3'b101:  len_scaled = {2'b00, tone_len[7:2]};
            3'b110:  len_scaled = {1'b0, prod3[15:9]};
            default: len_scaled = {1'b0, tone_len[7:1]};
        endcase
    end

    assign frag.freq  = {1'b0, freq_adj, 1'b0};
    assign frag.dur   = len_scaled;
    assign frag.pause = tone_pause;
    assign frag.rep   = repeat_count;
    assign frag.step  = freq_step;

endmodule

### hdl/bts_ring.sv
// Fragment ring storage: one write port, one registered read port with
// write forwarding. Depends on bts_pkg.
module bts_ring
    import bts_pkg::*;
#(
    parameter int DEPTH = 8,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  frag_t            wdata,
    input  logic [IDX_W-1:0] raddr,
    output frag_t            rdata
);
    frag_t mem [DEPTH];
    frag_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Forward a same-cycle write so the head word is never stale.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bts_player.sv
// Player state: ring pointers, urgent mark, current fragment, background
// tone and mode; works out one result word per processed item. Depends on bts_pkg.
module bts_player
    import bts_pkg::*;
#(
    parameter int DEPTH = 8,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  item_t            item,
    input  frag_t            head,
    output logic             ring_we,
    output logic [IDX_W-1:0] ring_waddr,
    output frag_t            ring_wdata,
    output logic [IDX_W-1:0] ring_raddr,
    output res_t             res
);
    frag_t            cur_reg, cur_next, cur_e;
    logic [8:0]       bg_freq_reg, bg_freq_next;
    logic [7:0]       bg_dur_reg, bg_dur_next, bg_dur_e;
    mode_t            mode_reg, mode_next;
    logic             tone_reg, tone_next;
    logic [IDX_W-1:0] ri_reg, ri_next;
    logic [IDX_W-1:0] wi_reg, wi_next;
    logic [IDX_W-1:0] ui_reg, ui_next;
    logic             uv_reg, uv_next;
    logic [IDX_W-1:0] slot;
    logic             use_bg;
    logic [9:0]       mult_in;
    logic [9:0]       swept;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
        return r;
    endfunction

    assign slot  = uv_reg ? ui_reg : ri_reg;
    assign swept = cur_e.freq + {{2{cur_e.step[7]}}, cur_e.step};

    always_comb
    begin
        cur_next     = cur_reg;
        cur_e        = uv_reg ? '0 : cur_reg;
        bg_dur_e     = uv_reg ? 8'd0 : bg_dur_reg;
        bg_freq_next = bg_freq_reg;
        bg_dur_next  = bg_dur_reg;
        mode_next    = mode_reg;
        tone_next    = tone_reg;
        ri_next      = ri_reg;
        wi_next      = wi_reg;
        ui_next      = ui_reg;
        uv_next      = uv_reg;
        ring_we      = 1'b0;
        ring_waddr   = wi_reg;
        ring_wdata   = item.frag;
        use_bg       = 1'b0;
        res          = '0;
        if (fire)
        begin
            case (item.action)
                ACT_ENQUEUE:
                begin
                    // Drop the word when the ring is full.
                    if (wrap_inc(wi_reg) != ri_reg)
                    begin
                        ring_we = 1'b1;
                        if (item.urgent)
                        begin
                            uv_next = 1'b1;
                            ui_next = wi_reg;
                        end
                        wi_next = wrap_inc(wi_reg);
                        res.accepted = 1'b1;
                        if (mode_reg == MODE_SLEEP)
                        begin
                            mode_next = MODE_RESUME;
                            res.wake_request = 1'b1;
                        end
                    end
                end
                ACT_BACKGROUND:
                begin
                    bg_freq_next = item.bg_freq;
                    bg_dur_next  = item.bg_len;
                    if (mode_reg == MODE_SLEEP)
                    begin
                        mode_next = MODE_RESUME;
                        res.wake_request = 1'b1;
                    end
                end
                ACT_WAKEUP:
                begin
                    // A pending urgent mark flushes the fragment in play.
                    cur_next    = cur_e;
                    bg_dur_next = bg_dur_e;
                    if (cur_e.dur != 8'd0)
                    begin
                        mode_next = MODE_TONE;
                        res.freq_valid = 1'b1;
                        if (cur_e.step != 8'd0)
                        begin
                            cur_next.freq = swept;
                            cur_next.dur  = cur_e.dur - 8'd1;
                            res.timer_ticks = 9'd2;
                        end
                        else
                        begin
                            cur_next.dur = 8'd0;
                            res.timer_ticks = {cur_e.dur, 1'b0};
                        end
                        tone_next = 1'b1;
                        res.timer_start = 1'b1;
                    end
                    else if (cur_e.pause != 8'd0)
                    begin
                        mode_next = MODE_TONE;
                        res.timer_ticks = {cur_e.pause, 1'b0};
                        cur_next.pause = 8'd0;
                        tone_next = 1'b0;
                        res.timer_start = 1'b1;
                    end
                    else if ((ri_reg == wi_reg) && !uv_reg && (bg_dur_e != 8'd0))
                    begin
                        mode_next = MODE_TONE;
                        res.timer_ticks = {bg_dur_e, 1'b0};
                        bg_dur_next = 8'd0;
                        res.freq_valid = 1'b1;
                        use_bg = 1'b1;
                        tone_next = 1'b1;
                        res.timer_start = 1'b1;
                    end
                    else if (ri_reg != wi_reg)
                    begin
                        if (uv_reg)
                        begin
                            uv_next   = 1'b0;
                            tone_next = 1'b0;
                            if (mode_reg == MODE_TONE)
                            begin
                                mode_next = MODE_RESUME;
                                res.timer_ticks = 9'd1;
                                res.timer_start = 1'b1;
                            end
                            else
                            begin
                                res.wake_request = 1'b1;
                            end
                        end
                        else
                        begin
                            res.wake_request = 1'b1;
                        end
                        // Take the slot, count down its repeats, advance past it at zero.
                        cur_next   = head;
                        ri_next    = (head.rep == 4'd0) ? wrap_inc(slot) : slot;
                        ring_we    = 1'b1;
                        ring_waddr = slot;
                        ring_wdata = head;
                        ring_wdata.rep = head.rep - 4'd1;
                    end
                    else
                    begin
                        mode_next = MODE_SLEEP;
                        tone_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        mult_in = use_bg ? {1'b0, bg_freq_reg} : cur_e.freq;
        res.tone_frequency = res.freq_valid ? 21'({11'd0, mult_in} * {10'd0, DAC_MULT}) : '0;
        res.tone_on = tone_next;
        res.player_state = mode_next;
    end

    // Prefetch the slot the next wakeup will take.
    assign ring_raddr = uv_next ? ui_next : ri_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            bg_freq_reg <= '0;
            bg_dur_reg  <= '0;
            mode_reg    <= MODE_SLEEP;
            tone_reg    <= 1'b0;
            ri_reg      <= '0;
            wi_reg      <= '0;
            ui_reg      <= '0;
            uv_reg      <= 1'b0;
        end
        else
        begin
            cur_reg     <= cur_next;
            bg_freq_reg <= bg_freq_next;
            bg_dur_reg  <= bg_dur_next;
            mode_reg    <= mode_next;
            tone_reg    <= tone_next;
            ri_reg      <= ri_next;
            wi_reg      <= wi_next;
            ui_reg      <= ui_next;
            uv_reg      <= uv_next;
        end
    end

    a_freq_needs_tone: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.freq_valid |-> res.tone_on)
        else $error("new frequency with tone disabled");

    a_wake_not_asleep: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.wake_request |-> res.player_state != MODE_SLEEP)
        else $error("wake request while sleeping");

    a_ring_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ring_we |-> (item.action == ACT_ENQUEUE) || (item.action == ACT_WAKEUP))
        else $error("ring written by a background word");

    a_accept_moves_wi: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.accepted |=> wi_reg != $past(wi_reg))
        else $error("accepted fragment did not advance write index");

endmodule

### hdl/beep_tone_sequencer.sv
// Beep tone sequencer: enqueue tone fragments into a ring, set a background
// tone and step playback on timer expiry; one result word for every input word.
// A word passes an input register, then the player logic into a result
// register, which offers its result word once the result side has room; a new
// word is taken every cycle while the result side keeps up, since the player
// state and the ring's registered head read are both ready for the word behind
// it. The ring is a synchronous memory of QUEUE_DEPTH entries with no clearing
// pass after reset. Configuration is a direct write with no wait state.
// Depends on bts_pkg and bts_ifs.
module beep_tone_sequencer
    import bts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    bts_in_if.sink  req,
    bts_out_if.source rsp,
    bts_cfg_if.sink cfg
);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic [7:0]       pitch_offset_reg;
    logic [2:0]       length_scale_reg;
    frag_t            prep_frag;
    item_t            item_reg, item_next;
    logic             item_valid_reg;
    res_t             rsp_reg;
    res_t             result;
    logic             rsp_valid_reg;
    logic             fire;
    frag_t            head;
    logic             ring_we;
    logic [IDX_W-1:0] ring_waddr;
    logic [IDX_W-1:0] ring_raddr;
    frag_t            ring_wdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_offset_reg <= '0;
            length_scale_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PITCH_OFFSET: pitch_offset_reg <= cfg.data;
                CFG_LENGTH_SCALE: length_scale_reg <= cfg.data[2:0];
                default:          pitch_offset_reg <= pitch_offset_reg;
            endcase
        end
    end

    bts_frag_prep u_prep (
        .tone_freq    (req.tone_freq),
        .tone_len     (req.tone_len),
        .tone_pause   (req.tone_pause),
        .repeat_count (req.repeat_count),
        .freq_step    (req.freq_step),
        .pitch_offset (pitch_offset_reg),
        .length_scale (length_scale_reg),
        .frag         (prep_frag)
    );

    always_comb
    begin
        item_next.action  = act_t'(req.action);
        item_next.urgent  = req.urgent;
        item_next.frag    = prep_frag;
        item_next.bg_freq = {req.tone_freq, 1'b0};
        item_next.bg_len  = req.tone_len;
    end

    // Process the held word when the result register is free or being drained.
    assign fire      = item_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= item_next;
        end
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    bts_ring #(.DEPTH(QUEUE_DEPTH)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (head)
    );

    bts_player #(.DEPTH(QUEUE_DEPTH)) u_player (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item_reg),
        .head       (head),
        .ring_we    (ring_we),
        .ring_waddr (ring_waddr),
        .ring_wdata (ring_wdata),
        .ring_raddr (ring_raddr),
        .res        (result)
    );

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.accepted       = rsp_reg.accepted;
    assign rsp.wake_request   = rsp_reg.wake_request;
    assign rsp.tone_on        = rsp_reg.tone_on;
    assign rsp.freq_valid     = rsp_reg.freq_valid;
    assign rsp.tone_frequency = rsp_reg.tone_frequency;
    assign rsp.timer_start    = rsp_reg.timer_start;
    assign rsp.timer_ticks    = rsp_reg.timer_ticks;
    assign rsp.player_state   = rsp_reg.player_state;

endmodule

### tb/tone_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the beep tone sequencer: tracks every input word through its own
// player model and compares each result word field by field, oldest first.
// Depends on bts_pkg and the channel interfaces in bts_ifs.
module tone_result_checker
    import bts_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic clk,
    input  logic rst_n,
    bts_in_if    req,
    bts_out_if   rsp,
    bts_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);

    localparam int REPORT_LINES = 100;

    frag_t      ring [DEPTH];
    int         rd_ptr;
    int         wr_ptr;
    bit         urgent_pending;
    int         urgent_slot;
    frag_t      playing;
    logic [9:0] bg_freq;
    logic [7:0] bg_len;
    mode_t      mode;
    bit         tone_level;
    logic [7:0] pitch_offset;
    logic [2:0] length_scale;
    res_t       expected_results [$];
    res_t       want;
    int         fail_count = 0;
    int         pending_count = 0;

    assign mismatches  = fail_count;
    assign outstanding = pending_count;

    task automatic report(input string msg);
        fail_count++;
        // keep the log readable when the model and the block part ways early
        if (fail_count <= REPORT_LINES)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [20:0] got,
                               input logic [20:0] expected);
        if (got !== expected)
            report($sformatf("%s got %0d, expected %0d", name, got, expected));
    endtask

    // Negative scale divides by one minus the scale, positive multiplies by one plus it.
    function automatic logic [7:0] scaled_len(input logic [7:0] len);
        int magn;
        int prod;
        if (length_scale[2]) begin
            magn = 8 - int'(length_scale);
            return 8'(int'(len) / (1 + magn));
        end
        prod = int'(len) * (1 + int'(length_scale));
        return prod[7:0];
    endfunction

    function automatic res_t advance_player(input logic [1:0] act, input logic [7:0] freq_in,
                                            input logic [7:0] len_in, input logic [7:0] pause_in,
                                            input logic [3:0] rep_in, input logic urgent_in,
                                            input logic [7:0] step_in);
        res_t       r;
        logic [7:0] f;
        int         nxt;
        int         slot;
        r = '0;
        case (act)
            ACT_ENQUEUE: begin
                f = freq_in;
                if (f != 8'd0)
                    f = f + pitch_offset;
                nxt = (wr_ptr + 1) % DEPTH;
                if (nxt != rd_ptr) begin
                    ring[wr_ptr].freq  = {1'b0, f, 1'b0};
                    ring[wr_ptr].dur   = scaled_len(len_in);
                    ring[wr_ptr].pause = pause_in;
                    ring[wr_ptr].rep   = rep_in;
                    ring[wr_ptr].step  = step_in;
                    if (urgent_in) begin
                        urgent_pending = 1'b1;
                        urgent_slot    = wr_ptr;
                    end
                    wr_ptr = nxt;
                    r.accepted = 1'b1;
                    if (mode == MODE_SLEEP) begin
                        mode = MODE_RESUME;
                        r.wake_request = 1'b1;
                    end
                end
            end
            ACT_BACKGROUND: begin
                bg_freq = {1'b0, freq_in, 1'b0};
                bg_len  = len_in;
                if (mode == MODE_SLEEP) begin
                    mode = MODE_RESUME;
                    r.wake_request = 1'b1;
                end
            end
            ACT_WAKEUP: begin
                // a pending jump drops whatever is playing and the background
                if (urgent_pending) begin
                    playing = '0;
                    bg_len  = 8'd0;
                end
                if (playing.dur != 8'd0) begin
                    mode = MODE_TONE;
                    r.freq_valid     = 1'b1;
                    r.tone_frequency = 21'(playing.freq) * 21'(DAC_MULT);
                    if (playing.step != 8'd0) begin
                        playing.freq = playing.freq + {{2{playing.step[7]}}, playing.step};
                        r.timer_ticks = 9'd2;
                        playing.dur = playing.dur - 8'd1;
                    end else begin
                        r.timer_ticks = {playing.dur, 1'b0};
                        playing.dur = 8'd0;
                    end
                    tone_level    = 1'b1;
                    r.timer_start = 1'b1;
                end else if (playing.pause != 8'd0) begin
                    mode = MODE_TONE;
                    r.timer_ticks = {playing.pause, 1'b0};
                    playing.pause = 8'd0;
                    tone_level    = 1'b0;
                    r.timer_start = 1'b1;
                end else if (rd_ptr == wr_ptr && !urgent_pending && bg_len != 8'd0) begin
                    mode = MODE_TONE;
                    r.timer_ticks    = {bg_len, 1'b0};
                    bg_len           = 8'd0;
                    r.freq_valid     = 1'b1;
                    r.tone_frequency = 21'(bg_freq) * 21'(DAC_MULT);
                    tone_level       = 1'b1;
                    r.timer_start    = 1'b1;
                end else if (rd_ptr != wr_ptr) begin
                    if (urgent_pending) begin
                        rd_ptr         = urgent_slot;
                        urgent_pending = 1'b0;
                        tone_level     = 1'b0;
                        playing        = '0;
                        if (mode == MODE_TONE) begin
                            mode = MODE_RESUME;
                            r.timer_ticks = 9'd1;
                            r.timer_start = 1'b1;
                        end else begin
                            r.wake_request = 1'b1;
                        end
                    end else begin
                        r.wake_request = 1'b1;
                    end
                    slot    = rd_ptr;
                    playing = ring[slot];
                    // advance only once the last repetition is taken
                    if (ring[slot].rep == 4'd0)
                        rd_ptr = (rd_ptr + 1) % DEPTH;
                    ring[slot].rep = ring[slot].rep - 4'd1;
                end else begin
                    mode       = MODE_SLEEP;
                    tone_level = 1'b0;
                end
            end
            default: ;
        endcase
        r.tone_on      = tone_level;
        r.player_state = mode;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++)
                ring[i] = '0;
            rd_ptr         = 0;
            wr_ptr         = 0;
            urgent_pending = 1'b0;
            urgent_slot    = 0;
            playing        = '0;
            bg_freq        = '0;
            bg_len         = '0;
            mode           = MODE_SLEEP;
            tone_level     = 1'b0;
            pitch_offset   = '0;
            length_scale   = '0;
            expected_results.delete();
            pending_count  = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == CFG_PITCH_OFFSET)
                    pitch_offset = cfg.data;
                else
                    length_scale = cfg.data[2:0];
            end
            if (req.valid && req.ready)
                expected_results.push_back(advance_player(req.action, req.tone_freq,
                    req.tone_len, req.tone_pause, req.repeat_count, req.urgent,
                    req.freq_step));
            if (rsp.valid && rsp.ready) begin
                if (expected_results.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", rsp.accepted, want.accepted);
                    check_field("wake_request", rsp.wake_request, want.wake_request);
                    check_field("tone_on", rsp.tone_on, want.tone_on);
                    check_field("freq_valid", rsp.freq_valid, want.freq_valid);
                    check_field("tone_frequency", rsp.tone_frequency, want.tone_frequency);
                    check_field("timer_start", rsp.timer_start, want.timer_start);
                    check_field("timer_ticks", rsp.timer_ticks, want.timer_ticks);
                    check_field("player_state", rsp.player_state, want.player_state);
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the beep tone sequencer testbench: clock, reset, input and configuration
// stimulus, result-side stalls and the verdict. Depends on bts_pkg, bts_ifs,
// beep_tone_sequencer and tone_result_checker.
module testbench;
    import bts_pkg::*;

    localparam int         QUEUE_DEPTH   = 8;
    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         PHASES        = 7;
    localparam int         PHASE_WORDS   = 150;
    localparam int         BURST_WORDS   = 30;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         SETTLE_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   outstanding;
    bit   hold_req = 1'b0;
    bit   no_idle = 1'b0;
    int   wake_pct = 50;

    bts_in_if  req_ch ();
    bts_out_if rsp_ch ();
    bts_cfg_if cfg_ch ();

    beep_tone_sequencer #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    tone_result_checker #(
        .DEPTH(QUEUE_DEPTH)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Leaves valid high on return; drain_results or the gap before a later word drops it.
    task automatic send_word(input logic [1:0] act, input logic [7:0] freq,
                             input logic [7:0] len, input logic [7:0] pause,
                             input logic [3:0] rep, input logic now, input logic [7:0] step);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.tone_freq    <= freq;
        req_ch.tone_len     <= len;
        req_ch.tone_pause   <= pause;
        req_ch.repeat_count <= rep;
        req_ch.urgent       <= now;
        req_ch.freq_step    <= step;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_wakeup();
        send_word(ACT_WAKEUP, 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                  1'($urandom), 8'($urandom));
    endtask

    task automatic send_random_word();
        int         pick;
        logic [1:0] act;
        logic [7:0] freq;
        logic [7:0] len;
        logic [7:0] pause;
        logic [3:0] rep;
        logic       now;
        logic [7:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            act = ACT_UNUSED;
        else if (pick < 10)
            act = ACT_BACKGROUND;
        else if (pick < 10 + wake_pct)
            act = ACT_WAKEUP;
        else
            act = ACT_ENQUEUE;
        // mostly short fragments so the ring keeps turning over
        freq  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        len   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 6));
        pause = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 3));
        rep   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 1));
        now   = ($urandom_range(0, 7) == 0);
        step  = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
        send_word(act, freq, len, pause, rep, now, step);
    endtask

    // Drop valid and wait until every expected result word has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] pitch, input int scale);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_PITCH_OFFSET;
        cfg_ch.data  <= pitch;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= CFG_LENGTH_SCALE;
        cfg_ch.data  <= 8'(scale);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random stalls, stretches without any, one long hold-off.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        req_ch.valid        <= 1'b0;
        req_ch.action       <= ACT_ENQUEUE;
        req_ch.tone_freq    <= '0;
        req_ch.tone_len     <= '0;
        req_ch.tone_pause   <= '0;
        req_ch.repeat_count <= '0;
        req_ch.urgent       <= 1'b0;
        req_ch.freq_step    <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_PITCH_OFFSET;
        cfg_ch.data         <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_regs(8'd0, 0);

        send_wakeup();                                   // empty ring: stay asleep
        send_word(ACT_BACKGROUND, 8'd0, 8'd1, 8'd0, 4'd0, 1'b0, 8'd0);
        // not sleeping any more; pause, repeat, urgent and step are ignored
        send_word(ACT_BACKGROUND, 8'd255, 8'd255, 8'd255, 4'd15, 1'b1, 8'h80);
        send_wakeup();                                   // longest background tone
        send_wakeup();                                   // nothing left: sleep
        send_word(ACT_ENQUEUE, 8'd255, 8'd255, 8'd255, 4'd15, 1'b0, 8'd0);
        send_wakeup();
        send_wakeup();
        // urgent fragment while a tone plays: jump, then sweep to the end
        send_word(ACT_ENQUEUE, 8'd1, 8'd3, 8'd0, 4'd0, 1'b1, 8'd127);
        repeat (5) send_wakeup();
        send_word(ACT_UNUSED, 8'd255, 8'd255, 8'd255, 4'd15, 1'b1, 8'hFF);
        // zero-frequency fragment sweeping down wraps the 10-bit frequency
        send_word(ACT_ENQUEUE, 8'd0, 8'd255, 8'd255, 4'd0, 1'b0, 8'h80);
        send_wakeup();
        send_wakeup();
        // fill the ring; the last word is dropped and its urgent flag with it
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_word(ACT_ENQUEUE, 8'($urandom), 8'($urandom_range(0, 4)),
                      8'($urandom_range(0, 2)), 4'd0, (i == 0 || i == QUEUE_DEPTH - 1),
                      8'($urandom));

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            write_regs((phase == 0) ? 8'd255 : (phase == 1) ? 8'd0 : 8'($urandom_range(0, 255)),
                       (phase % 5) - 2);
            wake_pct = 40 + 10 * (phase % 4);
            if (phase == 2)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                no_idle = (phase % 2 == 1) && (k < BURST_WORDS);
                send_random_word();
            end
            no_idle = 1'b0;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
